>>> sv/can_id_receiver_match_table_unit_defines.svh
// Assertion macros for the CAN receive filter table.
`ifndef CAN_ID_RECEIVER_MATCH_TABLE_UNIT_DEFINES_SVH
`define CAN_ID_RECEIVER_MATCH_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CIRMT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CIRMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/cirmt_pkg.sv
// Shared types and constants of the CAN receive filter table.
package cirmt_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam int ID_W     = 29;
    localparam int HANDLE_W = 16;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_REGISTER   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UNREGISTER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP     = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                ext;
        logic [ID_W-1:0]     ident;
    } entry_t;

    typedef enum logic [2:0] {
        PUSH_REG_OK,
        PUSH_FULL,
        PUSH_UNREG_OK,
        PUSH_MISS,
        PUSH_MORE,
        PUSH_FINAL
    } push_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REG,
        ST_UNREG_SCAN,
        ST_UNREG_RD,
        ST_UNREG_WR,
        ST_UNREG_MISS,
        ST_LOOK_SCAN,
        ST_LOOK_END
    } state_t;

    typedef struct packed {
        logic      accept;
        logic      scan_en;
        logic      push;
        push_sel_t push_sel;
        logic      hold_hit;
        logic      mark_hit;
        logic      tail_rd;
        logic      reg_wr;
        logic      move_wr;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic s1_hit;
        logic scan_done;
        logic full;
        logic held_valid;
    } sts_t;

endpackage

>>> sv/can_id_receiver_match_table_unit.sv
// Top level of the CAN receive filter table.
//
// Input stream: one transaction per request. tuser carries the request kind
// (register, unregister, lookup; the fourth code is dropped without a result).
// tdata carries the identifier, the extended flag and the handle to remove.
// Output stream: register and unregister give one transaction; a lookup
// gives one per matching filter in table order, tlast on the final one, or
// a single transaction with found clear. tuser holds status and the found flag.
// Unregister and lookup scan the N filters held in the entry memory one entry
// per cycle, a lookup's scan pausing while the output register is stalled.
// One request is in work at a time; the next is taken once the last result
// has moved into the output register, which frees the input side.
// A stalled receiver holds the output register; a lookup with a further
// match then pauses its scan until the transaction completes.
// Reset empties the table and restarts handles at zero; no clearing pass.
module can_id_receiver_match_table_unit
    import cirmt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // msg_id[28:0], extended[29], handle[45:30], zero pad
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // match_handle[15:0]
    output logic [2:0]  m_axis_tuser,  // status[1:0], found[2]
    output logic        m_axis_tlast
);

`include "can_id_receiver_match_table_unit_defines.svh"

    cmd_t                cmd;
    sts_t                sts;
    logic [STATUS_W-1:0] out_status;
    logic                out_found;

    cirmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_req   (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cirmt_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_req     (s_axis_tuser),
        .in_id      (s_axis_tdata[28:0]),
        .in_ext     (s_axis_tdata[29]),
        .in_handle  (s_axis_tdata[45:30]),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (out_status),
        .out_handle (m_axis_tdata),
        .out_found  (out_found),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tuser = {out_found, out_status};

    `CIRMT_ASSERT_SAME(a_push_free, cmd.push, sts.out_free, "result pushed into busy output")
    `CIRMT_ASSERT_SAME(a_reg_room, cmd.reg_wr, !sts.full, "filter written into full table")
    `CIRMT_ASSERT_SAME(a_hold_hit, cmd.hold_hit, sts.s1_hit, "match held without a hit")
    `CIRMT_ASSERT_NEXT(a_push_shown, cmd.push, m_axis_tvalid, "pushed result not presented")

endmodule

>>> sv/cirmt_ctrl.sv
// Controller state machine of the CAN receive filter table.
module cirmt_ctrl
    import cirmt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [REQ_W-1:0] in_req,
    output logic             in_ready,
    input  sts_t             sts,
    output cmd_t             cmd
);

    state_t state_reg;
    state_t state_next;
    logic   in_fire;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_req)
                        REQ_REGISTER:   state_next = ST_REG;
                        REQ_UNREGISTER: state_next = ST_UNREG_SCAN;
                        REQ_LOOKUP:     state_next = ST_LOOK_SCAN;
                        default:        state_next = ST_IDLE;
                    endcase
                end
            end
            ST_REG:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_UNREG_SCAN:
            begin
                priority if (sts.s1_hit)
                begin
                    state_next = ST_UNREG_RD;
                end
                else if (sts.scan_done)
                begin
                    state_next = ST_UNREG_MISS;
                end
                else
                begin
                    state_next = ST_UNREG_SCAN;
                end
            end
            ST_UNREG_RD:
            begin
                state_next = ST_UNREG_WR;
            end
            ST_UNREG_WR, ST_UNREG_MISS, ST_LOOK_END:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOOK_SCAN:
            begin
                if (!sts.s1_hit && sts.scan_done)
                begin
                    state_next = ST_LOOK_END;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_fire;
            end
            ST_REG:
            begin
                if (sts.out_free)
                begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = sts.full ? PUSH_FULL : PUSH_REG_OK;
                    cmd.reg_wr   = !sts.full;
                end
            end
            ST_UNREG_SCAN:
            begin
                priority if (sts.s1_hit)
                begin
                    cmd.mark_hit = 1'b1;
                end
                else
                begin
                    cmd.scan_en = !sts.scan_done;
                end
            end
            ST_UNREG_RD:
            begin
                cmd.tail_rd = 1'b1;
            end
            ST_UNREG_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = PUSH_UNREG_OK;
                    cmd.move_wr  = 1'b1;
                end
            end
            ST_UNREG_MISS:
            begin
                if (sts.out_free)
                begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = PUSH_MISS;
                end
            end
            ST_LOOK_SCAN:
            begin
                priority if (sts.s1_hit && sts.held_valid)
                begin
                    // previous match is not the final one; stall if output busy
                    if (sts.out_free)
                    begin
                        cmd.push     = 1'b1;
                        cmd.push_sel = PUSH_MORE;
                        cmd.hold_hit = 1'b1;
                        cmd.scan_en  = 1'b1;
                    end
                end
                else if (sts.s1_hit)
                begin
                    cmd.hold_hit = 1'b1;
                    cmd.scan_en  = 1'b1;
                end
                else
                begin
                    cmd.scan_en = !sts.scan_done;
                end
            end
            ST_LOOK_END:
            begin
                if (sts.out_free)
                begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = PUSH_FINAL;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/cirmt_dp.sv
// Datapath of the CAN receive filter table: entry memory, scan pipe, output register.
module cirmt_dp
    import cirmt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [REQ_W-1:0]    in_req,
    input  logic [ID_W-1:0]     in_id,
    input  logic                in_ext,
    input  logic [HANDLE_W-1:0] in_handle,
    input  cmd_t                cmd,
    output sts_t                sts,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [HANDLE_W-1:0] out_handle,
    output logic                out_found,
    output logic                out_last
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    entry_t entry_mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    logic [REQ_W-1:0]    req_reg;
    logic [ID_W-1:0]     id_reg;
    logic                ext_reg;
    logic [HANDLE_W-1:0] hnd_reg;

    logic [CNT_W-1:0]    count_reg;
    logic [HANDLE_W-1:0] next_handle_reg;
    logic [CNT_W-1:0]    ptr_reg;
    logic                s1_valid_reg;
    logic [IDX_W-1:0]    s1_idx_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic                held_valid_reg;
    logic [HANDLE_W-1:0] held_handle_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic                out_found_reg;
    logic                out_last_reg;

    logic                ptr_lt;
    logic [CNT_W-1:0]    tail_cnt;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    entry_t              wr_data;
    logic                look_hit;
    logic                unreg_hit;
    logic [STATUS_W-1:0] push_status;
    logic [HANDLE_W-1:0] push_handle;
    logic                push_found;
    logic                push_last;

    assign ptr_lt   = ptr_reg < count_reg;
    assign tail_cnt = count_reg - CNT_W'(1);
    assign rd_en    = (cmd.scan_en && ptr_lt) || cmd.tail_rd;
    assign rd_addr  = cmd.tail_rd ? tail_cnt[IDX_W-1:0] : ptr_reg[IDX_W-1:0];

    assign wr_en   = cmd.reg_wr || cmd.move_wr;
    assign wr_addr = cmd.move_wr ? hit_idx_reg : count_reg[IDX_W-1:0];
    always_comb
    begin
        wr_data.handle = next_handle_reg;
        wr_data.ext    = ext_reg;
        wr_data.ident  = id_reg;
        if (cmd.move_wr)
        begin
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign look_hit  = (rd_data_reg.ext == ext_reg) && (rd_data_reg.ident == id_reg);
    assign unreg_hit = (rd_data_reg.handle == hnd_reg);

    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.s1_hit     = s1_valid_reg && ((req_reg == REQ_LOOKUP) ? look_hit : unreg_hit);
    assign sts.scan_done  = !ptr_lt && !s1_valid_reg;
    assign sts.full       = count_reg >= CNT_W'(MAX_ENTRIES);
    assign sts.held_valid = held_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= in_req;
            id_reg  <= in_id;
            ext_reg <= in_ext;
            hnd_reg <= in_handle;
        end
        if (cmd.scan_en)
        begin
            s1_idx_reg <= ptr_reg[IDX_W-1:0];
        end
        if (cmd.mark_hit)
        begin
            hit_idx_reg <= s1_idx_reg;
        end
        if (cmd.hold_hit)
        begin
            held_handle_reg <= rd_data_reg.handle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            next_handle_reg <= '0;
            ptr_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            held_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.reg_wr)
            begin
                count_reg       <= count_reg + CNT_W'(1);
                next_handle_reg <= next_handle_reg + HANDLE_W'(1);
            end
            else if (cmd.move_wr)
            begin
                count_reg <= tail_cnt;
            end

            if (cmd.accept)
            begin
                ptr_reg        <= '0;
                s1_valid_reg   <= 1'b0;
                held_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_en)
                begin
                    s1_valid_reg <= ptr_lt;
                    if (ptr_lt)
                    begin
                        ptr_reg <= ptr_reg + CNT_W'(1);
                    end
                end
                else if (cmd.mark_hit)
                begin
                    s1_valid_reg <= 1'b0;
                end
                if (cmd.hold_hit)
                begin
                    held_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        push_status = STATUS_OK;
        push_handle = '0;
        push_found  = 1'b0;
        push_last   = 1'b1;
        unique case (cmd.push_sel)
            PUSH_REG_OK:
            begin
                push_handle = next_handle_reg;
            end
            PUSH_FULL:
            begin
                push_status = STATUS_FULL;
            end
            PUSH_UNREG_OK:
            begin
                push_status = STATUS_OK;
            end
            PUSH_MISS:
            begin
                push_status = STATUS_NOT_FOUND;
            end
            PUSH_MORE:
            begin
                push_handle = held_handle_reg;
                push_found  = 1'b1;
                push_last   = 1'b0;
            end
            PUSH_FINAL:
            begin
                if (held_valid_reg)
                begin
                    push_handle = held_handle_reg;
                    push_found  = 1'b1;
                end
            end
            default:
            begin
                push_status = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_status_reg <= push_status;
            out_handle_reg <= push_handle;
            out_found_reg  <= push_found;
            out_last_reg   <= push_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_handle = out_handle_reg;
    assign out_found  = out_found_reg;
    assign out_last   = out_last_reg;

endmodule

>>> tb/tb_can_id_receiver_match_table_unit.sv
`timescale 1ns / 100ps
// Testbench for the CAN receive filter table: directed and random requests vs. a predictor.
module tb_can_id_receiver_match_table_unit;
    import cirmt_pkg::*;

    localparam int MAX_FILTERS = MAX_ENTRIES_DEF;
    localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;
    localparam int RANDOM_REQUESTS = 140;
    localparam int CHUNK_REQUESTS = 30;
    localparam int LONG_HOLD = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE = 4;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] match_handle;
        logic                found;
        logic                last;
    } filter_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;  // msg_id[28:0], extended[29], handle[45:30], zero pad
    logic [1:0]  s_axis_tuser = '0;  // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;       // match_handle[15:0]
    logic [2:0]  m_axis_tuser;       // status[1:0], found[2]
    logic        m_axis_tlast;

    // predicted filter table
    logic [ID_W-1:0]     filter_ident [MAX_FILTERS];
    logic                filter_ext [MAX_FILTERS];
    logic [HANDLE_W-1:0] filter_handle [MAX_FILTERS];
    int                  filter_count = 0;
    logic [HANDLE_W-1:0] handle_counter = '0;

    filter_result_t expected_results [$];
    filter_result_t head_result;
    int             error_count = 0;
    int             cycle_count = 0;
    bit             src_idle = 1'b1;
    bit             sink_idle = 1'b1;
    int             sink_hold_request = 0;

    can_id_receiver_match_table_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_result(input logic [STATUS_W-1:0] status,
                               input logic [HANDLE_W-1:0] hnd,
                               input logic found, input logic last);
        filter_result_t r;
        r.status = status;
        r.match_handle = hnd;
        r.found = found;
        r.last = last;
        expected_results.push_back(r);
    endtask

    task automatic predict_filter_request(input logic [REQ_W-1:0] req,
                                          input logic [ID_W-1:0] id, input logic ext,
                                          input logic [HANDLE_W-1:0] hnd);
        int hits;
        int seen;
        int slot;
        hits = 0;
        seen = 0;
        slot = -1;
        case (req)
            REQ_REGISTER:
            begin
                if (filter_count >= MAX_FILTERS)
                    push_result(STATUS_FULL, '0, 1'b0, 1'b1);
                else
                begin
                    filter_ident[filter_count] = id;
                    filter_ext[filter_count] = ext;
                    filter_handle[filter_count] = handle_counter;
                    filter_count++;
                    push_result(STATUS_OK, handle_counter, 1'b0, 1'b1);
                    handle_counter = handle_counter + 1'b1;
                end
            end
            REQ_UNREGISTER:
            begin
                for (int i = 0; i < filter_count; i++)
                    if (slot < 0 && filter_handle[i] == hnd)
                        slot = i;
                if (slot < 0)
                    push_result(STATUS_NOT_FOUND, '0, 1'b0, 1'b1);
                else
                begin
                    filter_ident[slot] = filter_ident[filter_count-1];
                    filter_ext[slot] = filter_ext[filter_count-1];
                    filter_handle[slot] = filter_handle[filter_count-1];
                    filter_count--;
                    push_result(STATUS_OK, '0, 1'b0, 1'b1);
                end
            end
            REQ_LOOKUP:
            begin
                for (int i = 0; i < filter_count; i++)
                    if (filter_ext[i] == ext && filter_ident[i] == id)
                        hits++;
                if (hits == 0)
                    push_result(STATUS_OK, '0, 1'b0, 1'b1);
                for (int i = 0; i < filter_count; i++)
                    if (filter_ext[i] == ext && filter_ident[i] == id)
                    begin
                        seen++;
                        push_result(STATUS_OK, filter_handle[i], 1'b1, seen == hits);
                    end
            end
            default: ;
        endcase
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                                input logic ext, input logic [HANDLE_W-1:0] hnd);
        int gap;
        gap = src_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, hnd, ext, id};
        s_axis_tuser <= req;
        do @(posedge clk); while (!s_axis_tready);
        predict_filter_request(req, id, ext, hnd);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : result_sink
        int hold;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = sink_idle ? $urandom_range(0, 12) : 0;
            hold += sink_hold_request;
            sink_hold_request = 0;
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected transaction: status %0d, match_handle %0d",
                       m_axis_tuser[1:0], m_axis_tdata);
                error_count++;
            end
            else
            begin
                head_result = expected_results.pop_front();
                check_field("status", head_result.status, m_axis_tuser[1:0]);
                check_field("match_handle", head_result.match_handle, m_axis_tdata);
                check_field("found", head_result.found, m_axis_tuser[2]);
                check_field("last", head_result.last, m_axis_tlast);
            end
        end
    end

    task automatic test_register_extremes();
        send_request(REQ_REGISTER, 29'h0, 1'b0, 16'h0);
        send_request(REQ_REGISTER, 29'h1FFF_FFFF, 1'b1, 16'hFFFF);
        send_request(REQ_REGISTER, 29'h1FFF_FFFF, 1'b0, 16'h0);
        send_request(REQ_REGISTER, 29'h7FF, 1'b0, 16'h0);
    endtask

    task automatic test_lookup_cases();
        send_request(REQ_LOOKUP, 29'h1FFF_FFFF, 1'b1, 16'h0);
        send_request(REQ_LOOKUP, 29'h1FFF_FFFF, 1'b0, 16'hFFFF);
        send_request(REQ_LOOKUP, 29'h0, 1'b1, 16'h0);        // format differs
        send_request(REQ_LOOKUP, 29'h1FFF_FFFE, 1'b1, 16'h0);
        send_request(REQ_REGISTER, 29'h1FFF_FFFF, 1'b1, 16'h0);
        send_request(REQ_LOOKUP, 29'h1FFF_FFFF, 1'b1, 16'h0); // two matches
    endtask

    task automatic test_unregister_cases();
        send_request(REQ_UNREGISTER, 29'h0, 1'b0, 16'd1);     // last entry moves into slot
        send_request(REQ_LOOKUP, 29'h1FFF_FFFF, 1'b1, 16'h0);
        send_request(REQ_UNREGISTER, 29'h1FFF_FFFF, 1'b1, 16'hFFFF);
        send_request(REQ_UNREGISTER, 29'h0, 1'b0, 16'd1);     // already gone
        send_request(REQ_UNREGISTER, 29'h0, 1'b0, 16'd4);
    endtask

    task automatic test_ignored_request();
        send_request(REQ_IGNORED, 29'($urandom), 1'($urandom), 16'($urandom));
        send_request(REQ_LOOKUP, 29'h7FF, 1'b0, 16'h0);
    endtask

    // receiver opens with a long stall; table emptied, filled, overflowed and searched for 16 matches
    task automatic test_full_table_backpressure();
        logic [ID_W-1:0] id;
        id = 29'($urandom);
        wait_for_results();
        src_idle = 1'b0;
        sink_idle = 1'b0;
        sink_hold_request = LONG_HOLD;
        while (filter_count > 0)
            send_request(REQ_UNREGISTER, '0, 1'b0, filter_handle[0]);
        while (filter_count < MAX_FILTERS)
            send_request(REQ_REGISTER, id, 1'b1, 16'($urandom));
        send_request(REQ_REGISTER, 29'($urandom), 1'b0, 16'h0);
        send_request(REQ_LOOKUP, id, 1'b1, 16'h0);
        send_request(REQ_LOOKUP, id, 1'b0, 16'h0);
        wait_for_results();
        src_idle = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [ID_W-1:0] pool_id [POOL_SIZE];
        logic            pool_ext [POOL_SIZE];
        logic [ID_W-1:0] id;
        logic            ext;
        logic [HANDLE_W-1:0] hnd;
        int requests_sent;
        int reg_weight;
        int roll;
        int pick;
        requests_sent = 0;
        reg_weight = 30;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_id[i] = 29'($urandom);
            pool_ext[i] = 1'($urandom);
        end
        while (requests_sent < RANDOM_REQUESTS)
        begin
            if (requests_sent % CHUNK_REQUESTS == 0)
            begin
                case (requests_sent / CHUNK_REQUESTS)
                    0: begin src_idle = 1'b1; sink_idle = 1'b1; end
                    1: begin src_idle = 1'b0; sink_idle = 1'b0; end
                    default:
                    begin
                        src_idle = 1'($urandom);
                        sink_idle = 1'($urandom);
                    end
                endcase
                reg_weight = $urandom_range(15, 50);
            end
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, POOL_SIZE - 1);
            id = 29'($urandom);
            ext = 1'($urandom);
            hnd = 16'($urandom);
            if (roll < reg_weight)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    id = pool_id[pick];
                    ext = pool_ext[pick];
                end
                send_request(REQ_REGISTER, id, ext, hnd);
                requests_sent++;
            end
            else if (roll < 65)
            begin
                if (filter_count > 0 && $urandom_range(0, 3) != 0)
                    hnd = filter_handle[$urandom_range(0, filter_count - 1)];
                send_request(REQ_UNREGISTER, id, ext, hnd);
                requests_sent++;
            end
            else if (roll < 95)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5 && filter_count > 0)
                begin
                    pick = $urandom_range(0, filter_count - 1);
                    id = filter_ident[pick];
                    ext = filter_ext[pick];
                end
                else if (pick < 8)
                begin
                    id = pool_id[pick % POOL_SIZE];
                    ext = pool_ext[pick % POOL_SIZE];
                end
                send_request(REQ_LOOKUP, id, ext, hnd);
                requests_sent++;
            end
            else
                send_request(REQ_IGNORED, id, ext, hnd);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_register_extremes();
        test_lookup_cases();
        test_unregister_cases();
        test_ignored_request();
        test_full_table_backpressure();
        test_random_traffic();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
